// ----- hdl/fuzzy_subsequence_scorer_top_assert.svh -----
// Assertion macros shared by the scorer modules.
// Each macro expects clk in the enclosing module; FSS_ASSERT also expects rst_n.
`ifndef FUZZY_SUBSEQUENCE_SCORER_TOP_ASSERT_SVH
`define FUZZY_SUBSEQUENCE_SCORER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only outside reset
`define FSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define FSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FSS_ASSERT(lbl, prop, msg)
`define FSS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hdl/fss_pkg.sv -----
package fss_pkg;

  // Query store geometry
  localparam int QUERY_DEPTH = 32;
  localparam int QLEN_W      = $clog2(QUERY_DEPTH + 1);
  localparam int QIDX_W      = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
  localparam int PAIR_W      = QIDX_W;

  localparam int CHAR_W  = 8;
  localparam int TPOS_W  = 4;
  localparam int SCORE_W = 9;
  localparam int SUM_W   = (PAIR_W + 4 > SCORE_W + 1) ? PAIR_W + 4 : SCORE_W + 1;

  // Score terms
  localparam logic [SUM_W-1:0]  BASE_SCORE     = SUM_W'(20);
  localparam logic [SUM_W-1:0]  BOUNDARY_BONUS = SUM_W'(30);
  localparam logic [SUM_W-1:0]  PREFIX_BONUS   = SUM_W'(50);
  localparam logic [SUM_W-1:0]  SCORE_MAX      = SUM_W'({SCORE_W{1'b1}});
  localparam logic [TPOS_W-1:0] EARLY_LIMIT    = TPOS_W'(10);

  // ASCII classes
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_0   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_9   = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CASE_OFFSET    = 8'h20;

  typedef enum logic [1:0] {
    ACT_CLEAR     = 2'd0,
    ACT_APPEND    = 2'd1,
    ACT_TARGET    = 2'd2,
    ACT_EMPTY_END = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [CHAR_W-1:0]   char_code;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               matched;
  } res_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
           (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
           (c == CHAR_UNDERSCORE);
  endfunction

endpackage

// ----- hdl/fss_core.sv -----
`include "fuzzy_subsequence_scorer_top_assert.svh"

module fss_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  fss_pkg::item_t item,
  output logic          res_push,
  output fss_pkg::res_t res
);
  import fss_pkg::*;

  // Query store, written in append order; no reset
  logic [CHAR_W-1:0] query_store_r [QUERY_DEPTH];

  // Query and per-target match state
  logic [QLEN_W-1:0] query_length_r, query_length_nxt;
  logic [QLEN_W-1:0] match_index_r, match_index_nxt;
  logic [TPOS_W-1:0] first_position_r, first_position_nxt;
  logic              first_on_boundary_r, first_on_boundary_nxt;
  logic [PAIR_W-1:0] adjacent_pairs_r, adjacent_pairs_nxt;
  logic              previous_matched_r, previous_matched_nxt;
  logic              previous_is_word_r, previous_is_word_nxt;
  logic [TPOS_W-1:0] target_position_r, target_position_nxt;

  logic              store_wr;
  logic [CHAR_W-1:0] q_char;
  logic              hit;
  logic [QLEN_W-1:0] m_upd;
  logic [TPOS_W-1:0] fpos_upd;
  logic              bound_upd;
  logic [PAIR_W-1:0] adj_upd;
  logic [TPOS_W-1:0] tpos_upd;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_sat;
  logic [SCORE_W-1:0] final_score;

  // Match against the next query character
  always_comb begin
    q_char   = query_store_r[match_index_r[QIDX_W-1:0]];
    hit      = (item.action == ACT_TARGET) && (match_index_r < query_length_r) &&
               (fold_case(item.char_code) == fold_case(q_char));
    m_upd    = hit ? match_index_r + QLEN_W'(1) : match_index_r;
    fpos_upd = (hit && match_index_r == '0) ? target_position_r : first_position_r;
    bound_upd = (hit && match_index_r == '0) ?
                ((target_position_r == '0) || !previous_is_word_r) : first_on_boundary_r;
    adj_upd  = (hit && match_index_r != '0 && previous_matched_r) ?
               adjacent_pairs_r + PAIR_W'(1) : adjacent_pairs_r;
    tpos_upd = (target_position_r < EARLY_LIMIT) ?
               target_position_r + TPOS_W'(1) : target_position_r;
  end

  // Score of a finished target, from the updated state
  always_comb begin
    sum = BASE_SCORE + (SUM_W'(adj_upd) << 2) + SUM_W'(adj_upd) +
          SUM_W'(EARLY_LIMIT - fpos_upd);
    if (bound_upd) begin
      sum = sum + BOUNDARY_BONUS;
      if (QLEN_W'(adj_upd) + QLEN_W'(1) == query_length_r) begin
        sum = sum + PREFIX_BONUS;
      end
    end
    sum_sat = (sum > SCORE_MAX) ? SCORE_MAX : sum;
    if (query_length_r == '0) begin
      final_score = SCORE_W'(1);
    end else if (m_upd < query_length_r) begin
      final_score = '0;
    end else begin
      final_score = sum_sat[SCORE_W-1:0];
    end
  end

  // Next state and result
  always_comb begin
    query_length_nxt      = query_length_r;
    match_index_nxt       = match_index_r;
    first_position_nxt    = first_position_r;
    first_on_boundary_nxt = first_on_boundary_r;
    adjacent_pairs_nxt    = adjacent_pairs_r;
    previous_matched_nxt  = previous_matched_r;
    previous_is_word_nxt  = previous_is_word_r;
    target_position_nxt   = target_position_r;
    store_wr              = 1'b0;
    res_push              = 1'b0;
    res.score             = '0;
    res.matched           = 1'b0;
    if (item_valid) begin
      unique case (item.action)
        ACT_CLEAR: begin
          query_length_nxt      = '0;
          match_index_nxt       = '0;
          first_position_nxt    = '0;
          first_on_boundary_nxt = 1'b0;
          adjacent_pairs_nxt    = '0;
          previous_matched_nxt  = 1'b0;
          previous_is_word_nxt  = 1'b0;
          target_position_nxt   = '0;
        end
        ACT_APPEND: begin
          if (query_length_r < QLEN_W'(QUERY_DEPTH)) begin
            store_wr         = 1'b1;
            query_length_nxt = query_length_r + QLEN_W'(1);
          end
        end
        ACT_TARGET: begin
          if (item.last) begin
            match_index_nxt       = '0;
            first_position_nxt    = '0;
            first_on_boundary_nxt = 1'b0;
            adjacent_pairs_nxt    = '0;
            previous_matched_nxt  = 1'b0;
            previous_is_word_nxt  = 1'b0;
            target_position_nxt   = '0;
            res_push              = 1'b1;
            res.score             = final_score;
            res.matched           = (final_score != '0);
          end else begin
            match_index_nxt       = m_upd;
            first_position_nxt    = fpos_upd;
            first_on_boundary_nxt = bound_upd;
            adjacent_pairs_nxt    = adj_upd;
            previous_matched_nxt  = hit;
            previous_is_word_nxt  = is_word_char(item.char_code);
            target_position_nxt   = tpos_upd;
          end
        end
        ACT_EMPTY_END: begin
          match_index_nxt       = '0;
          first_position_nxt    = '0;
          first_on_boundary_nxt = 1'b0;
          adjacent_pairs_nxt    = '0;
          previous_matched_nxt  = 1'b0;
          previous_is_word_nxt  = 1'b0;
          target_position_nxt   = '0;
          res_push              = 1'b1;
          res.score             = SCORE_W'(query_length_r == '0);
          res.matched           = (query_length_r == '0);
        end
        default: begin
        end
      endcase
    end
  end

  // Query store write
  always_ff @(posedge clk) begin
    if (store_wr) begin
      query_store_r[query_length_r[QIDX_W-1:0]] <= item.char_code;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_length_r      <= '0;
      match_index_r       <= '0;
      first_position_r    <= '0;
      first_on_boundary_r <= 1'b0;
      adjacent_pairs_r    <= '0;
      previous_matched_r  <= 1'b0;
      previous_is_word_r  <= 1'b0;
      target_position_r   <= '0;
    end else begin
      query_length_r      <= query_length_nxt;
      match_index_r       <= match_index_nxt;
      first_position_r    <= first_position_nxt;
      first_on_boundary_r <= first_on_boundary_nxt;
      adjacent_pairs_r    <= adjacent_pairs_nxt;
      previous_matched_r  <= previous_matched_nxt;
      previous_is_word_r  <= previous_is_word_nxt;
      target_position_r   <= target_position_nxt;
    end
  end

  `FSS_ASSERT(a_match_in_query, match_index_r <= query_length_r, "match index past query length")
  `FSS_ASSERT(a_pairs_below_matches, adjacent_pairs_r == '0 || QLEN_W'(adjacent_pairs_r) < match_index_r, "adjacent pairs exceed matches")
  `FSS_ASSERT(a_clear_empties_query, item_valid && item.action == ACT_CLEAR |=> query_length_r == '0 && match_index_r == '0, "clear left query state")

endmodule

// ----- hdl/fss_outbuf.sv -----
`include "fuzzy_subsequence_scorer_top_assert.svh"

module fss_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fss_pkg::res_t push_data,
  output logic          room,
  output logic          out_valid,
  output fss_pkg::res_t out_data,
  input  logic          out_ready
);
  import fss_pkg::*;

  // Head register drives the port, skid entry catches a result during a stall
  logic  head_valid_r, head_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  res_t  head_data_r, head_data_nxt;
  res_t  skid_data_r, skid_data_nxt;
  logic  pop;

  always_comb begin
    pop            = head_valid_r && out_ready;
    head_valid_nxt = head_valid_r;
    head_data_nxt  = head_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (pop || !head_valid_r) begin
      if (skid_valid_r) begin
        head_valid_nxt = 1'b1;
        head_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        head_valid_nxt = push;
        head_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_data_r <= head_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign room      = !skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_data_r;

  `FSS_ASSERT_ALWAYS(a_skid_implies_head, !rst_n || !skid_valid_r || head_valid_r, "skid entry without head entry")
  `FSS_ASSERT(a_skid_moves_up, pop && skid_valid_r |=> head_valid_r && head_data_r == $past(skid_data_r), "skid entry lost on drain")
  `FSS_ASSERT(a_push_to_empty, push && !head_valid_r && !skid_valid_r |=> head_valid_r && head_data_r == $past(push_data), "result lost on empty buffer")

endmodule

// ----- hdl/fuzzy_subsequence_scorer_top.sv -----
// Fuzzy subsequence scorer. Load a query with append transactions (tuser =
// append, tdata = byte, up to 32 bytes kept), then stream target bytes with
// tuser = target and tlast on the final byte; that transaction yields one
// score transaction (0 = no case-insensitive subsequence match). An
// empty-target transaction scores 1 for an empty query and 0 otherwise, and a
// clear transaction empties the query. One input transaction is accepted every
// cycle while in_tready is high: each byte is matched against the next query
// byte with one compare and a few counter updates. The score is registered
// into the output buffer when the final target byte is accepted; a two-entry
// output buffer lets input continue during one stalled score and holds
// in_tready low only while two scores are waiting.
module fuzzy_subsequence_scorer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [8:0] score, [9] matched, [15:10] zero
);
  import fss_pkg::*;

  logic  accept;
  item_t item;
  logic  res_push;
  res_t  res;
  logic  room;
  res_t  out_res;

  // Input transaction
  assign accept         = in_tvalid && in_tready;
  assign item.action    = action_t'(in_tuser);
  assign item.char_code = in_tdata;
  assign item.last      = in_tlast;

  fss_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (accept),
    .item       (item),
    .res_push   (res_push),
    .res        (res)
  );

  fss_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_data  (out_res),
    .out_ready (out_tready)
  );

  assign in_tready = room;
  assign out_tdata = {6'd0, out_res.matched, out_res.score};

endmodule
